### rtl/core/tdi_pkg.sv
// Package for the tile deduplication indexer: sizes, register indexes and
// the dimension clamp. No dependencies.
package tdi_pkg;

   localparam int MAX_TILES    = 64;
   localparam int MAX_TILE_DIM = 16;

   localparam int SLOT_SIZE   = MAX_TILE_DIM * MAX_TILE_DIM;
   localparam int STORE_DEPTH = MAX_TILES * SLOT_SIZE;
   localparam int SLOT_W      = $clog2(MAX_TILES);
   localparam int CNT_W       = SLOT_W + 1;
   localparam int POS_W       = (SLOT_SIZE > 1) ? $clog2(SLOT_SIZE) : 1;
   localparam int ADDR_W      = SLOT_W + POS_W;

   localparam int DIM_W       = 5;
   localparam int AREA_W      = 2 * DIM_W;
   localparam int CHAN_W      = 8;
   localparam int PIX_W       = 3 * CHAN_W;
   localparam int IDX_W       = 6;
   localparam int CSR_IDX_W   = 4;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [DIM_W-1:0]     dim_type;
   typedef logic [CHAN_W-1:0]    chan_type;
   typedef logic [IDX_W-1:0]     tile_idx_type;

   localparam csr_idx_type CSR_TILE_WIDTH  = CSR_IDX_W'(0);
   localparam csr_idx_type CSR_TILE_HEIGHT = CSR_IDX_W'(1);

   function automatic dim_type clamp_dim(input dim_type value);
      dim_type result;
      result = value;
      if (value == '0) begin
         result = DIM_W'(1);
      end else if (value > DIM_W'(MAX_TILE_DIM)) begin
         result = DIM_W'(MAX_TILE_DIM);
      end
      return result;
   endfunction

endpackage

### rtl/core/tile_dedup_indexer_top.sv
// Tile deduplication indexer: compares each pixel against every stored tile
// through one memory read port and one comparator, then appends it. Uses tdi_pkg.
// A pixel is compared in ST_SCAN, then written in ST_WRITE if the store has room;
// the last pixel of a tile waits in ST_RESULT for a free response slot, and its
// result is registered. A new pixel is taken only in ST_IDLE, after the last is done.
// Reset: sizes 8 by 8, no stored tiles; the tile store is not cleared.
module tile_dedup_indexer_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tdi_pkg::chan_type     req_red,
   input  tdi_pkg::chan_type     req_green,
   input  tdi_pkg::chan_type     req_blue,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tdi_pkg::tile_idx_type rsp_tile_index,
   output logic                  rsp_is_new,
   output logic                  rsp_table_full,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  tdi_pkg::csr_idx_type  csr_index,
   input  tdi_pkg::dim_type      csr_wdata
);
   import tdi_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_WRITE  = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   dim_type                width_ff, width_in;
   dim_type                height_ff, height_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [MAX_TILES-1:0]   match_ff, match_in;
   logic [CNT_W-1:0]       iss_k_ff, iss_k_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0]      cmp_k_ff, cmp_k_in;
   logic                   found_ff, found_in;
   logic [SLOT_W-1:0]      found_k_ff, found_k_in;
   logic [PIX_W-1:0]       pix_ff, pix_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   tile_idx_type           rsp_idx_ff, rsp_idx_in;
   logic                   rsp_new_ff, rsp_new_in;
   logic                   rsp_full_ff, rsp_full_in;

   logic [PIX_W-1:0]       mem [STORE_DEPTH];
   logic [PIX_W-1:0]       mem_q_ff;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;

   logic [AREA_W-1:0]      total;
   logic                   last_pix;
   logic                   store_free;
   logic                   pix_eq;
   logic                   accept;
   logic                   csr_wr;
   logic                   slot_open;

   assign total      = AREA_W'(width_ff) * AREA_W'(height_ff);
   assign last_pix   = (AREA_W'(pos_ff) + AREA_W'(1)) >= total;
   assign store_free = cnt_ff < CNT_W'(MAX_TILES);
   assign pix_eq     = mem_q_ff == pix_ff;
   assign accept     = req_valid && !req_stall;
   assign csr_wr     = csr_valid && csr_ready;
   assign slot_open  = !rsp_vld_ff || !rsp_stall;

   assign req_stall  = state_ff != ST_IDLE;
   assign csr_ready  = state_ff == ST_IDLE;

   assign rd_en   = (state_ff == ST_SCAN) && (iss_k_ff < cnt_ff);
   assign rd_addr = {iss_k_ff[SLOT_W-1:0], pos_ff};
   assign wr_en   = (state_ff == ST_WRITE) && store_free;
   assign wr_addr = {cnt_ff[SLOT_W-1:0], pos_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= pix_ff;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      state_in    = state_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      match_in    = match_ff;
      iss_k_in    = iss_k_ff;
      cmp_vld_in  = 1'b0;
      cmp_k_in    = cmp_k_ff;
      found_in    = found_ff;
      found_k_in  = found_k_ff;
      pix_in      = pix_ff;
      rsp_vld_in  = rsp_vld_ff && rsp_stall;
      rsp_idx_in  = rsp_idx_ff;
      rsp_new_in  = rsp_new_ff;
      rsp_full_in = rsp_full_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pix_in   = {req_red, req_green, req_blue};
               iss_k_in = '0;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               cmp_vld_in = 1'b1;
               cmp_k_in   = iss_k_ff[SLOT_W-1:0];
               iss_k_in   = iss_k_ff + CNT_W'(1);
            end
            if (cmp_vld_ff) begin
               if (!pix_eq) begin
                  match_in[cmp_k_ff] = 1'b0;
               end else if (last_pix && match_ff[cmp_k_ff] && !found_ff) begin
                  found_in   = 1'b1;
                  found_k_in = cmp_k_ff;
               end
            end
            if (!rd_en && !cmp_vld_ff) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (last_pix) begin
               state_in = ST_RESULT;
            end else begin
               pos_in   = pos_ff + POS_W'(1);
               state_in = ST_IDLE;
            end
         end
         ST_RESULT: begin
            if (slot_open) begin
               rsp_vld_in = 1'b1;
               if (found_ff) begin
                  rsp_idx_in  = IDX_W'(found_k_ff);
                  rsp_new_in  = 1'b0;
                  rsp_full_in = 1'b0;
               end else if (store_free) begin
                  rsp_idx_in  = IDX_W'(cnt_ff);
                  rsp_new_in  = 1'b1;
                  rsp_full_in = 1'b0;
                  cnt_in      = cnt_ff + CNT_W'(1);
               end else begin
                  rsp_idx_in  = '0;
                  rsp_new_in  = 1'b0;
                  rsp_full_in = 1'b1;
               end
               pos_in   = '0;
               match_in = '1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // new sizes start a new image
      if (csr_wr) begin
         unique case (csr_index)
            CSR_TILE_WIDTH: begin
               width_in = clamp_dim(csr_wdata);
               cnt_in   = '0;
               pos_in   = '0;
               match_in = '1;
            end
            CSR_TILE_HEIGHT: begin
               height_in = clamp_dim(csr_wdata);
               cnt_in    = '0;
               pos_in    = '0;
               match_in  = '1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         width_ff   <= DIM_RESET;
         height_ff  <= DIM_RESET;
         cnt_ff     <= '0;
         pos_ff     <= '0;
         match_ff   <= '1;
         iss_k_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         cnt_ff     <= cnt_in;
         pos_ff     <= pos_in;
         match_ff   <= match_in;
         iss_k_ff   <= iss_k_in;
         cmp_vld_ff <= cmp_vld_in;
         found_ff   <= found_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_k_ff    <= cmp_k_in;
      found_k_ff  <= found_k_in;
      pix_ff      <= pix_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_tile_index = rsp_idx_ff;
   assign rsp_is_new     = rsp_new_ff;
   assign rsp_table_full = rsp_full_ff;

endmodule
